// ===== hdl/gzhs_pkg.sv =====
// ----------------------------------------------------------------------------
// gzhs_pkg
// Types and constants shared by the gzip header stripper modules.
// ----------------------------------------------------------------------------
package gzhs_pkg;

	localparam int unsigned LenW = 12;
	localparam logic [LenW-1:0] MaxHeaderLenReset = 12'd32;

	localparam logic [1:0] ST_BUSY  = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       finish;
	} gzhs_in_t;

	typedef struct packed {
		logic [7:0]      payload_byte;
		logic            payload_valid;
		logic [1:0]      status;
		logic [LenW-1:0] header_length;
	} gzhs_out_t;

	typedef enum logic [3:0] {
		PH_ID1,
		PH_ID2,
		PH_CM,
		PH_FLG,
		PH_FIXED,
		PH_XLEN_LO,
		PH_XLEN_HI,
		PH_EXTRA,
		PH_NAME,
		PH_COMMENT,
		PH_HCRC,
		PH_DONE,
		PH_ERR
	} gzhs_phase_t;

endpackage

// ===== hdl/gzhs_parser.sv =====
// ----------------------------------------------------------------------------
// gzhs_parser
// Header state machine: walks the gzip member header one byte per accepted
// item and forms the result for that item.
// ----------------------------------------------------------------------------
module gzhs_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  gzhs_pkg::gzhs_in_t             in_item,
	input  logic                           cfg_we,
	input  logic [gzhs_pkg::LenW-1:0]      cfg_wdata,
	output gzhs_pkg::gzhs_out_t            result
);
	import gzhs_pkg::*;

	localparam logic [7:0] Id1     = 8'h1F;
	localparam logic [7:0] Id2     = 8'h8B;
	localparam logic [7:0] CmDefl  = 8'd8;
	localparam int unsigned FHcrc    = 1;
	localparam int unsigned FExtra   = 2;
	localparam int unsigned FName    = 3;
	localparam int unsigned FComment = 4;
	localparam logic [LenW-1:0] CountMax = '1;

	gzhs_phase_t     phase_q, phase_d;
	logic [4:0]      flags_q, flags_d;
	logic [15:0]     rem_q, rem_d;
	logic [7:0]      xlo_q, xlo_d;
	logic [LenW-1:0] count_q, count_d;
	logic [LenW-1:0] max_len_q;

	function automatic gzhs_phase_t next_field(input logic [4:0] f);
		gzhs_phase_t p;
		if (f[FExtra])
			p = PH_XLEN_LO;
		else if (f[FName])
			p = PH_NAME;
		else if (f[FComment])
			p = PH_COMMENT;
		else if (f[FHcrc])
			p = PH_HCRC;
		else
			p = PH_DONE;
		return p;
	endfunction

	// Next state.
	always_comb begin
		logic [15:0] dec;
		logic [7:0]  b;
		logic        enter;
		dec     = rem_q - 16'd1;
		b       = in_item.data_byte;
		enter   = 1'b0;
		phase_d = phase_q;
		flags_d = flags_q;
		rem_d   = rem_q;
		xlo_d   = xlo_q;
		count_d = count_q;
		if (phase_q == PH_ERR) begin
			phase_d = PH_ERR;
		end else if (in_item.finish) begin
			if (phase_q != PH_DONE)
				phase_d = PH_ERR;
		end else if (phase_q != PH_DONE) begin
			if (count_q != CountMax)
				count_d = count_q + LenW'(1);
			unique case (phase_q) inside
				PH_ID1: begin
					phase_d = (b == Id1) ? PH_ID2 : PH_ERR;
				end
				PH_ID2: begin
					phase_d = (b == Id2) ? PH_CM : PH_ERR;
				end
				PH_CM: begin
					phase_d = (b == CmDefl) ? PH_FLG : PH_ERR;
				end
				PH_FLG: begin
					flags_d = b[4:0];
					rem_d   = 16'd6;
					phase_d = PH_FIXED;
				end
				PH_FIXED, PH_EXTRA: begin
					rem_d = dec;
					enter = (dec == 16'd0);
				end
				PH_XLEN_LO: begin
					xlo_d   = b;
					phase_d = PH_XLEN_HI;
				end
				PH_XLEN_HI: begin
					rem_d           = {b, xlo_q};
					flags_d[FExtra] = 1'b0;
					if ({b, xlo_q} == 16'd0)
						enter = 1'b1;
					else
						phase_d = PH_EXTRA;
				end
				PH_NAME: begin
					if (b == 8'd0) begin
						flags_d[FName] = 1'b0;
						enter          = 1'b1;
					end
				end
				PH_COMMENT: begin
					if (b == 8'd0) begin
						flags_d[FComment] = 1'b0;
						enter             = 1'b1;
					end
				end
				PH_HCRC: begin
					rem_d = dec;
					if (dec == 16'd0) begin
						flags_d[FHcrc] = 1'b0;
						enter          = 1'b1;
					end
				end
				default: begin
					phase_d = PH_ERR;
				end
			endcase
			if (enter) begin
				phase_d = next_field(flags_d);
				if (phase_d == PH_HCRC)
					rem_d = 16'd2;
			end
			// The length limit applies only to a header still in progress.
			if (phase_d != PH_DONE && phase_d != PH_ERR && count_d >= max_len_q)
				phase_d = PH_ERR;
		end
	end

	// Result for the item being accepted.
	always_comb begin
		result               = '0;
		result.header_length = count_d;
		if (phase_d == PH_ERR)
			result.status = ST_ERROR;
		else if (phase_d == PH_DONE)
			result.status = ST_DONE;
		else
			result.status = ST_BUSY;
		if (phase_q == PH_DONE && !in_item.finish) begin
			result.payload_valid = 1'b1;
			result.payload_byte  = in_item.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_ID1;
			flags_q   <= '0;
			rem_q     <= '0;
			xlo_q     <= '0;
			count_q   <= '0;
			max_len_q <= MaxHeaderLenReset;
		end else begin
			if (cfg_we)
				max_len_q <= cfg_wdata;
			if (accept) begin
				phase_q <= phase_d;
				flags_q <= flags_d;
				rem_q   <= rem_d;
				xlo_q   <= xlo_d;
				count_q <= count_d;
			end
		end
	end

`ifndef SYNTHESIS
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERR) |=> (phase_q == PH_ERR))
		else $error("error phase left");
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |=> (phase_q == PH_DONE))
		else $error("done phase left");
	a_count_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERR || phase_q == PH_DONE) |=> $stable(count_q))
		else $error("header count moved after header end");
`endif

endmodule

// ===== hdl/gzhs_skid.sv =====
// ----------------------------------------------------------------------------
// gzhs_skid
// Output register with a skid stage, so that a request can be taken while
// a finished result still waits downstream.
// ----------------------------------------------------------------------------
module gzhs_skid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  gzhs_pkg::gzhs_out_t in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output gzhs_pkg::gzhs_out_t out_data
);
	import gzhs_pkg::*;

	logic      out_valid_q, skid_valid_q;
	gzhs_out_t out_data_q, skid_data_q;
	logic      load;

	assign in_stall  = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign load      = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q  <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		else if (in_valid && !skid_valid_q)
			skid_data_q <= in_data;
	end

`ifndef SYNTHESIS
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage full with output register empty");
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled result dropped");
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !out_stall) |=> (out_valid_q && !skid_valid_q))
		else $error("skid stage did not move forward");
`endif

endmodule

// ===== hdl/gzhs_skid_unused_placeholder.sv =====
// ----------------------------------------------------------------------------
// gzhs_status_check
// Port-level check of the result stream of the stripper.
// ----------------------------------------------------------------------------
module gzhs_status_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                out_valid,
	input  gzhs_pkg::gzhs_out_t out_data
);
	import gzhs_pkg::*;

`ifndef SYNTHESIS
	a_payload_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.payload_valid) |-> (out_data.status == ST_DONE))
		else $error("payload byte outside a complete header");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status <= ST_ERROR))
		else $error("undefined status code");
	a_zero_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.payload_valid) |-> (out_data.payload_byte == 8'd0))
		else $error("payload byte not cleared");
`endif

endmodule

// ===== hdl/gzip_header_stripper_unit.sv =====
// ----------------------------------------------------------------------------
// gzip_header_stripper_unit
// Strips the gzip member header from a byte stream and passes the bytes
// after it on as payload, with header status and length on every result.
// ----------------------------------------------------------------------------
//  channel | handshake         | payload
//  --------+-------------------+-------------------------------------------
//  in      | in_valid/in_stall | data_byte, finish
//  out     | out_valid/out_stall | payload_byte, payload_valid, status,
//          |                   | header_length
//  cfg     | cfg_we            | cfg_wdata = max_header_len
//
// One request is taken per cycle while in_stall is low; its result is held in
// the output register, or the skid while out_stall holds it. The header FSM
// updates in the same cycle, so throughput is one byte per clock unstalled.
// A two-entry output stage (result register plus skid) lets one request in
// while a result is stalled; in_stall rises only when both are full.
// Reset returns to the first magic byte with max_header_len at 32.
// ----------------------------------------------------------------------------
module gzip_header_stripper_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  gzhs_pkg::gzhs_in_t        in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output gzhs_pkg::gzhs_out_t       out_data,
	input  logic                      cfg_we,
	input  logic [gzhs_pkg::LenW-1:0] cfg_wdata
);
	import gzhs_pkg::*;

	gzhs_out_t result;
	logic      accept;

	assign accept = in_valid && !in_stall;

	gzhs_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_item   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

	gzhs_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (result),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	gzhs_status_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gzip_header_stripper_unit. One member header with
// every optional field present is parsed after reset, followed by a long
// stream of payload bytes and finish markers. Each accepted request is run
// through a bit-true predictor and the result is compared field by field.
// Both sides idle at random, with one long receiver hold-off and a drain
// of the sender before each change of the header limit.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gzhs_pkg::*;

	localparam logic [7:0] MagicId1 = 8'h1F;
	localparam logic [7:0] MagicId2 = 8'h8B;
	localparam logic [7:0] MethodDeflate = 8'h08;
	localparam logic [4:0] FlagHcrc = 5'h02;
	localparam logic [4:0] FlagExtra = 5'h04;
	localparam logic [4:0] FlagName = 5'h08;
	localparam logic [4:0] FlagComment = 5'h10;
	localparam logic [15:0] FixedFieldBytes = 16'd6;
	localparam logic [15:0] HcrcBytes = 16'd2;
	localparam logic [LenW-1:0] MinHeaderLen = 12'd10;
	localparam logic [LenW-1:0] MaxHeaderLen = 12'd4095;
	localparam int LongHoldCycles = 64;
	localparam int DrainCycles = 4;
	localparam int WatchdogLimit = 4000;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	gzhs_in_t in_data;
	logic out_valid;
	logic out_stall;
	gzhs_out_t out_data;
	logic cfg_we;
	logic [LenW-1:0] cfg_wdata;

	// Predictor state.
	gzhs_phase_t parse_ph;
	logic [4:0] hdr_flags;
	logic [15:0] field_left;
	logic [7:0] xlen_low;
	logic [LenW-1:0] hdr_count;
	logic hdr_error;
	logic [LenW-1:0] hdr_limit;

	gzhs_out_t expected_results[$];
	int fail_count = 0;
	int quiet_cycles = 0;
	bit idle_en = 1'b1;
	bit long_hold = 1'b0;

	gzip_header_stripper_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic void flag_error();
		parse_ph = PH_ERR;
		hdr_error = 1'b1;
	endfunction

	// Optional fields are taken in the order the format lays them down.
	function automatic void next_header_field();
		if ((hdr_flags & FlagExtra) != '0) begin
			parse_ph = PH_XLEN_LO;
		end else if ((hdr_flags & FlagName) != '0) begin
			parse_ph = PH_NAME;
		end else if ((hdr_flags & FlagComment) != '0) begin
			parse_ph = PH_COMMENT;
		end else if ((hdr_flags & FlagHcrc) != '0) begin
			parse_ph = PH_HCRC;
			field_left = HcrcBytes;
		end else begin
			parse_ph = PH_DONE;
		end
	endfunction

	function automatic gzhs_out_t strip_request(input gzhs_in_t req);
		gzhs_out_t res;
		logic [7:0] b;
		res = '0;
		b = req.data_byte;
		if (hdr_error) begin
			parse_ph = PH_ERR;
		end else if (req.finish) begin
			if (parse_ph != PH_DONE) flag_error();
		end else if (parse_ph == PH_DONE) begin
			res.payload_valid = 1'b1;
			res.payload_byte = b;
		end else begin
			if (hdr_count != '1) hdr_count = hdr_count + 1'b1;
			case (parse_ph) inside
				PH_ID1: if (b == MagicId1) parse_ph = PH_ID2; else flag_error();
				PH_ID2: if (b == MagicId2) parse_ph = PH_CM; else flag_error();
				PH_CM: if (b == MethodDeflate) parse_ph = PH_FLG; else flag_error();
				PH_FLG: begin
					hdr_flags = b[4:0];
					field_left = FixedFieldBytes;
					parse_ph = PH_FIXED;
				end
				PH_FIXED, PH_EXTRA: begin
					field_left = field_left - 1'b1;
					if (field_left == '0) next_header_field();
				end
				PH_XLEN_LO: begin
					xlen_low = b;
					parse_ph = PH_XLEN_HI;
				end
				PH_XLEN_HI: begin
					field_left = {b, xlen_low};
					hdr_flags = hdr_flags & ~FlagExtra;
					if (field_left == '0) next_header_field();
					else parse_ph = PH_EXTRA;
				end
				PH_NAME: begin
					if (b == '0) begin
						hdr_flags = hdr_flags & ~FlagName;
						next_header_field();
					end
				end
				PH_COMMENT: begin
					if (b == '0) begin
						hdr_flags = hdr_flags & ~FlagComment;
						next_header_field();
					end
				end
				PH_HCRC: begin
					field_left = field_left - 1'b1;
					if (field_left == '0) begin
						hdr_flags = hdr_flags & ~FlagHcrc;
						next_header_field();
					end
				end
				default: flag_error();
			endcase
			// The limit is checked once the byte has been counted.
			if (parse_ph != PH_DONE && parse_ph != PH_ERR && hdr_count >= hdr_limit)
				flag_error();
		end
		res.status = hdr_error ? ST_ERROR : (parse_ph == PH_DONE) ? ST_DONE : ST_BUSY;
		res.header_length = hdr_count;
		return res;
	endfunction

	function automatic void check_field(input string what, input logic [LenW-1:0] want,
			input logic [LenW-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		gzhs_out_t want;
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h", $time, out_data);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("payload_byte", LenW'(want.payload_byte),
					LenW'(out_data.payload_byte));
				check_field("payload_valid", LenW'(want.payload_valid),
					LenW'(out_data.payload_valid));
				check_field("status", LenW'(want.status), LenW'(out_data.status));
				check_field("header_length", want.header_length, out_data.header_length);
			end
		end
		if (in_valid && !in_stall) expected_results.push_back(strip_request(in_data));
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
		else quiet_cycles++;
	end

	initial begin : watchdog
		wait (quiet_cycles >= WatchdogLimit);
		$display("CHECK FAILED");
		$finish;
	end

	// Receiver: random stall bursts, or one long hold-off when asked.
	initial begin : receiver
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (LongHoldCycles) @(posedge clk);
				out_stall <= 1'b0;
				long_hold = 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_request(input logic [7:0] b, input logic fin);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, finish: fin};
		do @(posedge clk); while (in_stall);
	endtask

	// The extra edge lets the last accepted request reach the queue first.
	task automatic write_max_len(input logic [LenW-1:0] limit);
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= limit;
		hdr_limit = limit;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_config_extremes();
		write_max_len(MinHeaderLen);
		write_max_len(MaxHeaderLen);
	endtask

	// One header with every optional field; the limit is set to the exact
	// length, one short of it, or the largest value.
	task automatic test_header_fields();
		logic [7:0] hdr[$];
		logic [7:0] flg;
		int unsigned xlen;
		int unsigned pick;
		hdr = {MagicId1, MagicId2, MethodDeflate};
		flg = 8'($urandom_range(0, 255));
		flg[4:1] = 4'b1111;
		hdr.push_back(flg);
		repeat (6) hdr.push_back(8'($urandom_range(0, 255)));
		xlen = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
		hdr.push_back(8'(xlen));
		hdr.push_back(8'h00);
		repeat (xlen) hdr.push_back(8'($urandom_range(0, 255)));
		repeat ($urandom_range(1, 3)) hdr.push_back(8'($urandom_range(1, 255)));
		hdr.push_back(8'h00);
		repeat ($urandom_range(0, 3)) hdr.push_back(8'($urandom_range(1, 255)));
		hdr.push_back(8'h00);
		repeat (2) hdr.push_back(8'($urandom_range(0, 255)));
		pick = $urandom_range(0, 5);
		if (pick == 0) write_max_len(LenW'(hdr.size() - 1));
		else if (pick == 1) write_max_len(MaxHeaderLen);
		else write_max_len(LenW'(hdr.size()));
		foreach (hdr[i]) send_request(hdr[i], 1'b0);
		send_request(8'h5A, 1'b1);
		send_request(8'h00, 1'b0);
		send_request(8'hFF, 1'b0);
		send_request(8'hA5, 1'b1);
	endtask

	task automatic test_random_stream(input int unsigned count, input bit allow_idle);
		for (int i = 0; i < count; i++) begin
			if (!allow_idle) idle_en = 1'b0;
			else if (i % 100 == 0) idle_en = ($urandom_range(0, 3) != 0);
			send_request(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
		end
	endtask

	// The sender keeps offering requests while results are held back, so
	// the output stage fills and the input stalls.
	task automatic test_receiver_hold();
		idle_en = 1'b0;
		long_hold = 1'b1;
		repeat (24) send_request(8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic test_drain_and_reconfigure();
		idle_en = 1'b1;
		write_max_len(LenW'($urandom_range(MinHeaderLen, MaxHeaderLen)));
		test_random_stream(60, 1'b1);
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		parse_ph = PH_ID1;
		hdr_flags = '0;
		field_left = '0;
		xlen_low = '0;
		hdr_count = '0;
		hdr_error = 1'b0;
		hdr_limit = MaxHeaderLenReset;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_config_extremes();
		test_header_fields();
		test_random_stream(1650, 1'b1);
		test_receiver_hold();
		test_drain_and_reconfigure();
		test_random_stream(120, 1'b0);
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
